// ===== hw/rtl/rvg_pkg.sv =====
// ----------------------------------------------------------------------------
// rvg_pkg
// Shared types and constants of the radial vignetting gain block.
// ----------------------------------------------------------------------------
package rvg_pkg;

  localparam int COORD_BITS_DEF  = 13;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int SIZE_W     = 14;
  localparam int STRENGTH_W = 16;
  localparam int NORM_W     = 48;
  localparam int CH_W       = 16;
  localparam int D2_W       = 20;
  localparam int GAIN_W     = 36;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_STRENGTH = 2'd2,
    CFG_NORM     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [NORM_W-1:0]            norm;
    logic signed [STRENGTH_W-1:0] strength;
    logic [SIZE_W-1:0]            height;
    logic [SIZE_W-1:0]            width;
  } cfg_t;

  typedef struct packed {
    logic            last;
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pix_t;

endpackage

// ===== hw/rtl/rvg_front.sv =====
// ----------------------------------------------------------------------------
// rvg_front
// Accepts pixels, tracks column and row, forms the squared center offset
// and the frame end flag, and pushes each pixel into the queue.
// ----------------------------------------------------------------------------
module rvg_front #(
  parameter int COORD_BITS = rvg_pkg::COORD_BITS_DEF,
  parameter int Q_W        = 2 * COORD_BITS + 3 + $bits(rvg_pkg::pix_t)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rvg_pkg::cfg_t                 cfg,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [4*rvg_pkg::CH_W-1:0]    in_tdata,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [Q_W-1:0]                q_wdata
);

  localparam int CB   = COORD_BITS;
  localparam int SQ_W = 2 * CB + 3;
  localparam logic [CB:0] SIZE_CAP = (CB + 1)'(1) << CB;

  function automatic logic [CB:0] eff_size(input logic [rvg_pkg::SIZE_W-1:0] v);
    logic [CB:0] r;
    if (v == '0) begin
      r = (CB + 1)'(1);
    end else if (v > SIZE_CAP) begin
      r = SIZE_CAP;
    end else begin
      r = (CB + 1)'(v);
    end
    return r;
  endfunction

  logic [CB-1:0]          col_r, col_nxt;
  logic [CB-1:0]          row_r, row_nxt;
  logic [CB:0]            w_eff, h_eff;
  logic [CB:0]            col_p1, row_p1;
  logic signed [CB+1:0]   ex, ey;
  logic [CB:0]            ax, ay;
  logic [2*CB+1:0]        sqx, sqy;
  logic [SQ_W-1:0]        sumsq;
  logic                   row_end, frame_end;
  rvg_pkg::pix_t          pix;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    w_eff     = eff_size(cfg.width);
    h_eff     = eff_size(cfg.height);
    col_p1    = {1'b0, col_r} + (CB + 1)'(1);
    row_p1    = {1'b0, row_r} + (CB + 1)'(1);
    row_end   = col_p1 >= w_eff;
    frame_end = row_end && (row_p1 >= h_eff);

    ex  = $signed({1'b0, col_r, 1'b1}) - $signed({1'b0, w_eff});
    ey  = $signed({1'b0, row_r, 1'b1}) - $signed({1'b0, h_eff});
    ax  = ex[CB+1] ? (CB + 1)'(-ex) : ex[CB:0];
    ay  = ey[CB+1] ? (CB + 1)'(-ey) : ey[CB:0];
    sqx = (2 * CB + 2)'(ax) * (2 * CB + 2)'(ax);
    sqy = (2 * CB + 2)'(ay) * (2 * CB + 2)'(ay);
    sumsq = SQ_W'(sqx) + SQ_W'(sqy);

    pix.red   = in_tdata[rvg_pkg::CH_W-1:0];
    pix.green = in_tdata[2*rvg_pkg::CH_W-1:rvg_pkg::CH_W];
    pix.blue  = in_tdata[3*rvg_pkg::CH_W-1:2*rvg_pkg::CH_W];
    pix.alpha = in_tdata[4*rvg_pkg::CH_W-1:3*rvg_pkg::CH_W];
    pix.last  = frame_end;
    q_wdata   = {sumsq, pix};

    if (frame_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = row_p1[CB-1:0];
    end else begin
      col_nxt = col_p1[CB-1:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (q_push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== hw/rtl/rvg_queue.sv =====
// ----------------------------------------------------------------------------
// rvg_queue
// Small register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rvg_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = rvg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full  = count_r == CNT_FULL;
  assign valid = count_r != '0;
  assign rdata = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNT_FULL))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue pop while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not follow push");
`endif

endmodule

// ===== hw/rtl/rvg_back.sv =====
// ----------------------------------------------------------------------------
// rvg_back
// Sequencer that turns the squared offset into a gain, scales the color
// samples with it and holds the result beat for the output channel.
// ----------------------------------------------------------------------------
module rvg_back #(
  parameter int COORD_BITS  = rvg_pkg::COORD_BITS_DEF,
  parameter int SAMPLE_BITS = rvg_pkg::SAMPLE_BITS_DEF,
  parameter int Q_W         = 2 * COORD_BITS + 3 + $bits(rvg_pkg::pix_t)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rvg_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  logic [Q_W-1:0]                q_rdata,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [4*rvg_pkg::CH_W-1:0]    out_tdata,
  output logic                          out_tlast
);

  localparam int SQ_W = 2 * COORD_BITS + 3;
  localparam int MP_W = SQ_W + 24;
  localparam int T_W  = SQ_W + 26;
  localparam int R_W  = SQ_W + 17;
  localparam int SEW  = (SAMPLE_BITS < rvg_pkg::CH_W) ? SAMPLE_BITS : rvg_pkg::CH_W;
  localparam int PR_W = SEW + rvg_pkg::GAIN_W + 1;
  localparam int PW0  = SEW + 7;
  localparam int PW1  = (PW0 > SAMPLE_BITS + 1) ? PW0 : SAMPLE_BITS + 1;
  localparam int PW   = (PW1 > rvg_pkg::CH_W + 1) ? PW1 : rvg_pkg::CH_W + 1;

  localparam logic [T_W-1:0]     T_HALF   = T_W'(64'd1 << 31);
  localparam logic [PR_W-1:0]    P_HALF   = PR_W'(64'd1 << 29);
  localparam logic [PW-1:0]      SAMP_MAX = PW'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic signed [37:0] ONE_Q30  = 38'sd1073741824;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL_HI = 3'd1;
  localparam logic [2:0] ST_MUL_LO = 3'd2;
  localparam logic [2:0] ST_ROUND  = 3'd3;
  localparam logic [2:0] ST_GAIN   = 3'd4;
  localparam logic [2:0] ST_SC_R   = 3'd5;
  localparam logic [2:0] ST_SC_G   = 3'd6;
  localparam logic [2:0] ST_SC_B   = 3'd7;

  logic [2:0]                    state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;
  rvg_pkg::pix_t                 pix_r, out_pix_r;
  logic [SQ_W-1:0]               sumsq_r;
  logic [MP_W-1:0]               hi_r, lo_r, mprod;
  logic [rvg_pkg::D2_W-1:0]      d2q_r, d2q;
  logic [rvg_pkg::GAIN_W-1:0]    gain_r, gain;
  logic [rvg_pkg::CH_W-1:0]      red_res_r, green_res_r, scaled;
  logic [23:0]                   norm_half;
  logic [T_W-1:0]                t_sum;
  logic [R_W-1:0]                r_sum;
  logic signed [37:0]            s_ext, d_ext, g_s;
  logic [rvg_pkg::CH_W-1:0]      sel_samp;
  logic [PR_W-1:0]               sprod;
  logic [PW-1:0]                 p_val, p_sat;
  logic                          out_free, out_load;

  assign out_free   = !out_valid_r || out_tready;
  assign out_load   = (state_r == ST_SC_B) && out_free;
  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pix_r.alpha, out_pix_r.blue, out_pix_r.green, out_pix_r.red};
  assign out_tlast  = out_pix_r.last;

  always_comb begin
    norm_half = (state_r == ST_MUL_HI) ? cfg.norm[47:24] : cfg.norm[23:0];
    mprod     = MP_W'(sumsq_r) * MP_W'(norm_half);

    t_sum = T_W'({hi_r[7:0], 24'd0}) + T_W'(lo_r) + T_HALF;
    r_sum = R_W'(hi_r[MP_W-1:8]) + R_W'(t_sum[T_W-1:32]);
    d2q   = (|r_sum[R_W-1:rvg_pkg::D2_W]) ? '1 : r_sum[rvg_pkg::D2_W-1:0];

    s_ext = 38'(cfg.strength);
    d_ext = 38'($signed({1'b0, d2q_r}));
    g_s   = ONE_Q30 + s_ext * d_ext;
    gain  = (g_s > 38'sd0) ? g_s[rvg_pkg::GAIN_W-1:0] : '0;

    unique case (state_r)
      ST_SC_R: sel_samp = pix_r.red;
      ST_SC_G: sel_samp = pix_r.green;
      default: sel_samp = pix_r.blue;
    endcase
    sprod  = PR_W'(sel_samp[SEW-1:0]) * PR_W'(gain_r) + P_HALF;
    p_val  = PW'(sprod[PR_W-1:30]);
    p_sat  = (p_val > SAMP_MAX) ? SAMP_MAX : p_val;
    scaled = p_sat[rvg_pkg::CH_W-1:0];
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE:   state_nxt = q_valid ? ST_MUL_HI : ST_IDLE;
      ST_MUL_HI: state_nxt = ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_GAIN;
      ST_GAIN:   state_nxt = ST_SC_R;
      ST_SC_R:   state_nxt = ST_SC_G;
      ST_SC_G:   state_nxt = ST_SC_B;
      ST_SC_B:   state_nxt = out_free ? ST_IDLE : ST_SC_B;
      default:   state_nxt = ST_IDLE;
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sumsq_r <= q_rdata[Q_W-1:Q_W-SQ_W];
      pix_r   <= q_rdata[$bits(rvg_pkg::pix_t)-1:0];
    end
    if (state_r == ST_MUL_HI) begin
      hi_r <= mprod;
    end
    if (state_r == ST_MUL_LO) begin
      lo_r <= mprod;
    end
    if (state_r == ST_ROUND) begin
      d2q_r <= d2q;
    end
    if (state_r == ST_GAIN) begin
      gain_r <= gain;
    end
    if (state_r == ST_SC_R) begin
      red_res_r <= scaled;
    end
    if (state_r == ST_SC_G) begin
      green_res_r <= scaled;
    end
    if (out_load) begin
      out_pix_r.red   <= red_res_r;
      out_pix_r.green <= green_res_r;
      out_pix_r.blue  <= scaled;
      out_pix_r.alpha <= pix_r.alpha;
      out_pix_r.last  <= pix_r.last;
    end
  end

`ifndef ASSERT_OFF
  a_load_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_SC_B))
    else $error("result beat loaded outside the last scaling step");

  a_pop_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_MUL_HI))
    else $error("popped item did not start the sequencer");
`endif

endmodule

// ===== hw/rtl/radial_vignetting_gain.sv =====
// ----------------------------------------------------------------------------
// radial_vignetting_gain
// The back-end sequencer takes a new pixel from the queue only once the last
// one has been loaded into the output register, and it runs the norm, gain and
// per-channel scaling multiplies one step at a time.
// Reset: counters at zero, width and height 1, strength and norm 0,
// queue and output register empty; no clearing pass.
// ----------------------------------------------------------------------------
module radial_vignetting_gain #(
  parameter int COORD_BITS  = rvg_pkg::COORD_BITS_DEF,
  parameter int SAMPLE_BITS = rvg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // red_in, green_in, blue_in, alpha_in
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [4*rvg_pkg::CH_W-1:0]    in_tdata,
  // red_out, green_out, blue_out, alpha_out
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [4*rvg_pkg::CH_W-1:0]    out_tdata,
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [rvg_pkg::NORM_W-1:0]    cfg_wdata
);

  localparam int Q_W = 2 * COORD_BITS + 3 + $bits(rvg_pkg::pix_t);

  rvg_pkg::cfg_t   cfg_r;
  logic            q_full, q_push, q_valid, q_pop;
  logic [Q_W-1:0]  q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width    <= rvg_pkg::SIZE_W'(1);
      cfg_r.height   <= rvg_pkg::SIZE_W'(1);
      cfg_r.strength <= '0;
      cfg_r.norm     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rvg_pkg::CFG_WIDTH:    cfg_r.width    <= cfg_wdata[rvg_pkg::SIZE_W-1:0];
        rvg_pkg::CFG_HEIGHT:   cfg_r.height   <= cfg_wdata[rvg_pkg::SIZE_W-1:0];
        rvg_pkg::CFG_STRENGTH: cfg_r.strength <= $signed(cfg_wdata[rvg_pkg::STRENGTH_W-1:0]);
        rvg_pkg::CFG_NORM:     cfg_r.norm     <= cfg_wdata;
      endcase
    end
  end

  rvg_front #(
    .COORD_BITS (COORD_BITS),
    .Q_W        (Q_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  rvg_queue #(
    .DATA_W (Q_W),
    .DEPTH  (rvg_pkg::QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  rvg_back #(
    .COORD_BITS  (COORD_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .Q_W         (Q_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
